### hdl/fjp_pkg.sv
// Shared types and constants for the flat JSON object parser.
`timescale 1ns / 1ps
`default_nettype none
package fjp_pkg;

  localparam int NUMBER_BITS_DEF = 64;
  localparam int NUM_W           = 64;
  localparam int RUN_MAX         = 5;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [3:0] {
    PH_OPEN, PH_FIRST, PH_KEY, PH_STR, PH_ESC, PH_HEX, PH_LOW_BS, PH_LOW_U,
    PH_LOW_HEX, PH_COLON, PH_VALUE, PH_LIT, PH_NUM, PH_AFTER, PH_END
  } phase_t;

  typedef enum logic [3:0] {
    TK_KEY_BYTE  = 4'd0,
    TK_KEY_END   = 4'd1,
    TK_VAL_BYTE  = 4'd2,
    TK_VAL_END   = 4'd3,
    TK_TRUE      = 4'd4,
    TK_FALSE     = 4'd5,
    TK_NUMBER    = 4'd6,
    TK_ACCEPTED  = 4'd7,
    TK_ERROR     = 4'd8
  } tok_t;

  typedef struct packed {
    logic [2:0]                cnt;
    logic [RUN_MAX-1:0][3:0]   kind;
    logic [RUN_MAX-1:0][7:0]   data;
    logic [NUM_W-1:0]          num;
  } run_t;

  function automatic logic [7:0] word_true(input logic [1:0] pos);
    logic [7:0] r;
    unique case (pos)
      2'd0: r = 8'h74;
      2'd1: r = 8'h72;
      2'd2: r = 8'h75;
      default: r = 8'h65;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] word_false(input logic [2:0] pos);
    logic [7:0] r;
    unique case (pos)
      3'd0: r = 8'h66;
      3'd1: r = 8'h61;
      3'd2: r = 8'h6C;
      3'd3: r = 8'h73;
      default: r = 8'h65;
    endcase
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

endpackage
`default_nettype wire

### hdl/fjp_front.sv
// Front end: parser state and per-byte token run formation.
`timescale 1ns / 1ps
`default_nettype none
module fjp_front #(
  parameter int NUMBER_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_input,
  output logic             push,
  output fjp_pkg::run_t    run
);
  import fjp_pkg::*;

  phase_t                 phase, phase_next;
  logic                   in_key, in_key_next;
  logic [15:0]            hex_acc, hex_acc_next;
  logic [1:0]             hex_cnt, hex_cnt_next;
  logic [9:0]             hi_sur, hi_sur_next;
  logic [NUMBER_BITS-1:0] num_acc, num_acc_next;
  logic [2:0]             lit_pos, lit_pos_next;
  logic                   lit_true, lit_true_next;
  logic                   failed, failed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_OPEN;
      in_key   <= 1'b0;
      hex_acc  <= '0;
      hex_cnt  <= '0;
      hi_sur   <= '0;
      num_acc  <= '0;
      lit_pos  <= '0;
      lit_true <= 1'b0;
      failed   <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      in_key   <= in_key_next;
      hex_acc  <= hex_acc_next;
      hex_cnt  <= hex_cnt_next;
      hi_sur   <= hi_sur_next;
      num_acc  <= num_acc_next;
      lit_pos  <= lit_pos_next;
      lit_true <= lit_true_next;
      failed   <= failed_next;
    end
  end

  always_comb begin
    logic [2:0]  n;
    logic        go;
    logic        digit;
    logic [3:0]  dval;
    logic [4:0]  hval;
    logic [15:0] acc4;
    logic [20:0] cp;
    logic        put;
    logic [3:0]  bk;
    logic [2:0]  len;
    logic [7:0]  want;
    phase_next    = phase;
    in_key_next   = in_key;
    hex_acc_next  = hex_acc;
    hex_cnt_next  = hex_cnt;
    hi_sur_next   = hi_sur;
    num_acc_next  = num_acc;
    lit_pos_next  = lit_pos;
    lit_true_next = lit_true;
    failed_next   = failed;
    run           = '0;
    n             = '0;
    go            = 1'b1;
    cp            = '0;
    put           = 1'b0;
    want          = '0;
    len           = '0;
    acc4          = '0;
    digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    dval  = 4'(in_byte - 8'h30);
    if (digit) hval = {1'b0, dval};
    else if (in_byte >= 8'h61 && in_byte <= 8'h66) hval = 5'(in_byte - 8'h57);
    else if (in_byte >= 8'h41 && in_byte <= 8'h46) hval = 5'(in_byte - 8'h37);
    else hval = 5'h10;
    bk = in_key ? TK_KEY_BYTE : TK_VAL_BYTE;

    if (!failed) begin
      if (phase == PH_NUM) begin
        if (digit) begin
          num_acc_next = (num_acc << 3) + (num_acc << 1) + NUMBER_BITS'(dval);
          go = 1'b0;
        end else begin
          run.kind[n] = TK_NUMBER;
          run.num     = NUM_W'(num_acc);
          n = n + 3'd1;
          num_acc_next = '0;
          phase_next = PH_AFTER;
        end
      end
      if (go) begin
        unique case (phase_next)
          PH_OPEN: begin
            if (!is_ws(in_byte)) begin
              if (in_byte == 8'h7B) phase_next = PH_FIRST;
              else failed_next = 1'b1;
            end
          end
          PH_FIRST, PH_KEY: begin
            if (!is_ws(in_byte)) begin
              if (in_byte == 8'h22) begin
                in_key_next = 1'b1;
                phase_next = PH_STR;
              end else if (in_byte == 8'h7D && phase == PH_FIRST) phase_next = PH_END;
              else failed_next = 1'b1;
            end
          end
          PH_STR: begin
            if (in_byte == 8'h22) begin
              run.kind[n] = in_key ? TK_KEY_END : TK_VAL_END;
              n = n + 3'd1;
              phase_next = in_key ? PH_COLON : PH_AFTER;
            end else if (in_byte < 8'h20) failed_next = 1'b1;
            else if (in_byte == 8'h5C) phase_next = PH_ESC;
            else begin
              run.kind[n] = bk;
              run.data[n] = in_byte;
              n = n + 3'd1;
            end
          end
          PH_ESC: begin
            phase_next = PH_STR;
            unique case (in_byte)
              8'h22, 8'h5C, 8'h2F: begin cp = 21'(in_byte); put = 1'b1; end
              8'h62: begin cp = 21'h08; put = 1'b1; end
              8'h66: begin cp = 21'h0C; put = 1'b1; end
              8'h6E: begin cp = 21'h0A; put = 1'b1; end
              8'h72: begin cp = 21'h0D; put = 1'b1; end
              8'h74: begin cp = 21'h09; put = 1'b1; end
              8'h75: begin
                phase_next = PH_HEX;
                hex_acc_next = '0;
                hex_cnt_next = '0;
              end
              default: failed_next = 1'b1;
            endcase
          end
          PH_HEX, PH_LOW_HEX: begin
            if (hval[4]) failed_next = 1'b1;
            else begin
              acc4 = {hex_acc[11:0], hval[3:0]};
              hex_acc_next = acc4;
              if (hex_cnt != 2'd3) hex_cnt_next = hex_cnt + 2'd1;
              else begin
                hex_cnt_next = '0;
                hex_acc_next = '0;
                if (phase == PH_HEX) begin
                  if (acc4 >= 16'hD800 && acc4 <= 16'hDBFF) begin
                    hi_sur_next = acc4[9:0];
                    phase_next = PH_LOW_BS;
                  end else if (acc4 >= 16'hDC00) begin
                    failed_next = 1'b1;
                    if (acc4 > 16'hDFFF) begin
                      failed_next = 1'b0;
                      cp = 21'(acc4);
                      put = 1'b1;
                      phase_next = PH_STR;
                    end
                  end else begin
                    cp = 21'(acc4);
                    put = 1'b1;
                    phase_next = PH_STR;
                  end
                end else begin
                  if (acc4 < 16'hDC00 || acc4 > 16'hDFFF) failed_next = 1'b1;
                  else begin
                    cp = 21'h10000 + {1'b0, hi_sur, acc4[9:0]};
                    put = 1'b1;
                    phase_next = PH_STR;
                  end
                end
              end
            end
          end
          PH_LOW_BS: begin
            if (in_byte == 8'h5C) phase_next = PH_LOW_U;
            else failed_next = 1'b1;
          end
          PH_LOW_U: begin
            if (in_byte == 8'h75) begin
              phase_next = PH_LOW_HEX;
              hex_acc_next = '0;
              hex_cnt_next = '0;
            end else failed_next = 1'b1;
          end
          PH_COLON: begin
            if (!is_ws(in_byte)) begin
              if (in_byte == 8'h3A) phase_next = PH_VALUE;
              else failed_next = 1'b1;
            end
          end
          PH_VALUE: begin
            if (!is_ws(in_byte)) begin
              if (in_byte == 8'h22) begin
                in_key_next = 1'b0;
                phase_next = PH_STR;
              end else if (in_byte == 8'h74 || in_byte == 8'h66) begin
                lit_true_next = (in_byte == 8'h74);
                lit_pos_next = 3'd1;
                phase_next = PH_LIT;
              end else if (digit) begin
                num_acc_next = NUMBER_BITS'(dval);
                phase_next = PH_NUM;
              end else failed_next = 1'b1;
            end
          end
          PH_LIT: begin
            len = lit_true ? 3'd4 : 3'd5;
            want = lit_true ? word_true(lit_pos[1:0]) : word_false(lit_pos);
            if (lit_pos >= len || in_byte != want) failed_next = 1'b1;
            else begin
              lit_pos_next = lit_pos + 3'd1;
              if (lit_pos + 3'd1 == len) begin
                run.kind[n] = lit_true ? TK_TRUE : TK_FALSE;
                n = n + 3'd1;
                lit_pos_next = '0;
                phase_next = PH_AFTER;
              end
            end
          end
          PH_AFTER: begin
            if (!is_ws(in_byte)) begin
              if (in_byte == 8'h7D) phase_next = PH_END;
              else if (in_byte == 8'h2C) phase_next = PH_KEY;
              else failed_next = 1'b1;
            end
          end
          PH_END: begin
            if (!is_ws(in_byte)) failed_next = 1'b1;
          end
          default: failed_next = 1'b1;
        endcase
      end
      if (put) begin
        if (cp < 21'h80) begin
          run.kind[n] = bk; run.data[n] = cp[7:0]; n = n + 3'd1;
        end else if (cp < 21'h800) begin
          run.kind[n] = bk; run.data[n] = {3'b110, cp[10:6]}; n = n + 3'd1;
          run.kind[n] = bk; run.data[n] = {2'b10, cp[5:0]}; n = n + 3'd1;
        end else if (cp < 21'h10000) begin
          run.kind[n] = bk; run.data[n] = {4'b1110, cp[15:12]}; n = n + 3'd1;
          run.kind[n] = bk; run.data[n] = {2'b10, cp[11:6]}; n = n + 3'd1;
          run.kind[n] = bk; run.data[n] = {2'b10, cp[5:0]}; n = n + 3'd1;
        end else begin
          run.kind[n] = bk; run.data[n] = {5'b11110, cp[20:18]}; n = n + 3'd1;
          run.kind[n] = bk; run.data[n] = {2'b10, cp[17:12]}; n = n + 3'd1;
          run.kind[n] = bk; run.data[n] = {2'b10, cp[11:6]}; n = n + 3'd1;
          run.kind[n] = bk; run.data[n] = {2'b10, cp[5:0]}; n = n + 3'd1;
        end
      end
      if (failed_next) begin
        run.kind[n] = TK_ERROR;
        n = n + 3'd1;
      end
      if (end_of_input && !failed_next) begin
        if (phase_next == PH_NUM) begin
          run.kind[n] = TK_NUMBER;
          run.num     = NUM_W'(num_acc_next);
          n = n + 3'd1;
          phase_next = PH_AFTER;
        end
        run.kind[n] = (phase_next == PH_END) ? TK_ACCEPTED : TK_ERROR;
        n = n + 3'd1;
      end
    end
    if (end_of_input) begin
      phase_next    = PH_OPEN;
      in_key_next   = 1'b0;
      hex_acc_next  = '0;
      hex_cnt_next  = '0;
      hi_sur_next   = '0;
      num_acc_next  = '0;
      lit_pos_next  = '0;
      lit_true_next = 1'b0;
      failed_next   = 1'b0;
    end
    run.cnt = n;
    push = accept && (n != 3'd0);
  end

endmodule
`default_nettype wire

### hdl/fjp_back.sv
// Back end: run queue and token serialiser.
`timescale 1ns / 1ps
`default_nettype none
module fjp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fjp_pkg::run_t run,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [3:0]         token_kind,
  output logic [7:0]         data_byte,
  output logic [63:0]        number_value,
  output logic               last_of_run
);
  import fjp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  run_t          q [QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;
  logic [2:0]    idx;
  logic          pop;
  run_t          head;

  assign head        = q[rp];
  assign full        = (count == (PW+1)'(QUEUE_DEPTH));
  assign out_valid   = (count != '0);
  assign token_kind  = head.kind[idx];
  assign data_byte   = head.data[idx];
  assign number_value = (head.kind[idx] == TK_NUMBER) ? head.num : '0;
  assign last_of_run = (idx + 3'd1 == head.cnt);
  assign pop         = out_valid && !out_stall && last_of_run;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      if (push) wp <= wp + PW'(1);
      if (pop) rp <= rp + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
      if (out_valid && !out_stall) idx <= last_of_run ? 3'd0 : idx + 3'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (idx < head.cnt)) else $error("token index beyond run");

endmodule
`default_nettype wire

### hdl/flat_json_object_parser.sv
// Top level of the flat JSON object parser.
// One byte per cycle is accepted while the run queue is not full; each token
// run is registered there, and one token per cycle leaves it unless stalled.
// Multi-byte UTF-8 runs of up to five tokens drain from a four-run queue.
// Synchronous active-high reset returns the parser to expect an opening brace.
`timescale 1ns / 1ps
`default_nettype none
module flat_json_object_parser #(
  parameter int NUMBER_BITS = fjp_pkg::NUMBER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       token_kind,
  output logic [7:0]       data_byte,
  output logic [63:0]      number_value,
  output logic             last_of_run
);
  import fjp_pkg::*;

  logic full, push, accept;
  run_t run;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  fjp_front #(.NUMBER_BITS(NUMBER_BITS)) u_front (
    .clk, .rst, .accept, .in_byte, .end_of_input, .push, .run
  );

  fjp_back u_back (
    .clk, .rst, .push, .run, .full, .out_valid, .out_stall,
    .token_kind, .data_byte, .number_value, .last_of_run
  );

endmodule
`default_nettype wire
